[design/ktt_pkg.sv]
// Shared types, field widths and codes for the keyed timer table.
package ktt_pkg;

	localparam int SLOTS_DEF = 16;

	localparam int TYPE_W   = 4;
	localparam int SUB_W    = 8;
	localparam int KEY_W    = 32;
	localparam int TIME_W   = 32;
	localparam int PERIOD_W = 24;
	localparam int TAG_W    = 16;
	localparam int DELTA_W  = 16;
	localparam int STATUS_W = 2;
	localparam int MODE_W   = 2;
	// Width of period plus startup delta before it is added to a time.
	localparam int INCR_W   = PERIOD_W + 1;

	localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TICK   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

	// Input beat payload, last field in the lowest bits.
	typedef struct packed {
		logic [1:0]          pad;
		logic [TIME_W-1:0]   now_time;
		logic [TAG_W-1:0]    tag_in;
		logic                periodic;
		logic [PERIOD_W-1:0] period;
		logic [KEY_W-1:0]    timer_key;
		logic                any_subtype;
		logic [SUB_W-1:0]    timer_subtype;
		logic [TYPE_W-1:0]   timer_type;
	} in_beat_t;

	localparam int IN_DATA_W = $bits(in_beat_t);

	// One stored timer.
	typedef struct packed {
		logic [TYPE_W-1:0]   slot_type;
		logic [SUB_W-1:0]    slot_subtype;
		logic [KEY_W-1:0]    slot_key;
		logic [TIME_W-1:0]   slot_expiry;
		logic [PERIOD_W-1:0] slot_period;
		logic                slot_periodic;
		logic [TAG_W-1:0]    slot_tag;
	} entry_t;

endpackage

[design/ktt_sat_add.sv]
// Saturating time adder shared by timer insertion and periodic reload.
module ktt_sat_add
	import ktt_pkg::*;
(
	input  logic [TIME_W-1:0] a,
	input  logic [INCR_W-1:0] b,
	output logic [TIME_W-1:0] sum
);

	logic [TIME_W:0] full_sum;

	assign full_sum = {1'b0, a} + (TIME_W+1)'(b);
	assign sum      = full_sum[TIME_W] ? {TIME_W{1'b1}} : full_sum[TIME_W-1:0];

endmodule

[design/keyed_timer_table_unit.sv]
// Top level of the keyed timer table: command sequencer, slot memory and result register.
//
// Commands arrive on the s_ stream, one beat per command, with the mode in s_tuser.
// Results leave on the m_ stream; m_tlast marks the final result of a command.
// startup_delta is written through cfg_valid/cfg_data and must only change while idle.
// Timers sit in a single-port slot memory with registered read data, kept in
// insertion order; deletion compacts the table in the same pass that visits it.
// Each visited slot is addressed, then evaluated and written back.
// Add goes from its decision straight to its result. Remove and lookup scan the live
// timers (lookup stops at its first match). Tick makes a counting pass and a firing pass,
// and one result per fired timer is issued during the second pass.
// s_tready is high only while the sequencer is idle; the next command may be taken
// while the last result still waits in the output register.
// A stalled receiver holds the output register and pauses a tick at the next firing
// timer. Reset empties the table and clears startup_delta; the slot memory itself is
// not cleared.
module keyed_timer_table_unit
	import ktt_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF,
	localparam int CW = $clog2(SLOTS + 1),
	localparam int OUT_W = STATUS_W + 1 + TYPE_W + SUB_W + KEY_W + TAG_W + CW,
	localparam int OUT_DATA_W = ((OUT_W + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// timer_type, timer_subtype, any_subtype, timer_key, period, periodic, tag_in, now_time
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// mode
	input  logic [MODE_W-1:0]     s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// status, fired, out_type, out_subtype, out_key, tag_out, live_count
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [DELTA_W-1:0]    cfg_data
);

	localparam int IW = $clog2(SLOTS);
	localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);
	localparam logic [CW-1:0] ONE_C   = CW'(1);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_DECIDE  = 3'd1;
	localparam logic [2:0] S_CNT_RD  = 3'd2;
	localparam logic [2:0] S_CNT_EV  = 3'd3;
	localparam logic [2:0] S_SCAN_RD = 3'd4;
	localparam logic [2:0] S_SCAN_EV = 3'd5;
	localparam logic [2:0] S_FIN     = 3'd6;

	logic [2:0]          state_q;
	logic [MODE_W-1:0]   mode_q;
	in_beat_t            req_q;
	logic [DELTA_W-1:0]  delta_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       rd_idx_q;
	logic [CW-1:0]       wr_idx_q;
	logic                found_q;
	logic [CW-1:0]       nfire_q;
	logic [CW-1:0]       ndel_q;
	logic [CW-1:0]       emit_q;
	logic [CW-1:0]       fcnt_q;
	logic [STATUS_W-1:0] status_q;
	logic [TAG_W-1:0]    tag_q;

	entry_t              mem_q [SLOTS];
	entry_t              rdata_q;

	logic                m_tvalid_q;
	logic [STATUS_W-1:0] o_status_q;
	logic                o_fired_q;
	logic [TYPE_W-1:0]   o_type_q;
	logic [SUB_W-1:0]    o_sub_q;
	logic [KEY_W-1:0]    o_key_q;
	logic [TAG_W-1:0]    o_tag_q;
	logic [CW-1:0]       o_live_q;
	logic                o_last_q;

	in_beat_t            beat;
	entry_t              ent;
	entry_t              wdata;
	logic                we;
	logic [IW-1:0]       waddr;
	logic                re;
	logic [TIME_W-1:0]   add_a;
	logic [INCR_W-1:0]   add_b;
	logic [TIME_W-1:0]   add_sum;
	logic                out_free;
	logic                add_bad;
	logic                tk_eq;
	logic                exact_eq;
	logic                fire;
	logic                rm_del;
	logic                tick_hold;
	logic                scan_end;
	logic                load_fire;
	logic                load_fin;

	assign beat      = in_beat_t'(s_tdata);
	assign ent       = rdata_q;
	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !m_tvalid_q || m_tready;

	assign add_bad  = (req_q.timer_type == '0) || (req_q.period == '0);
	assign tk_eq    = (ent.slot_type == req_q.timer_type) && (ent.slot_key == req_q.timer_key);
	assign exact_eq = tk_eq && (ent.slot_subtype == req_q.timer_subtype);
	assign fire     = (req_q.now_time > ent.slot_expiry);
	assign rm_del   = tk_eq && (req_q.any_subtype ||
		((ent.slot_subtype == req_q.timer_subtype) && !found_q));
	assign scan_end = (rd_idx_q == count_q);

	assign tick_hold = (state_q == S_SCAN_EV) && (mode_q == MODE_TICK) && fire && !out_free;
	assign load_fire = (state_q == S_SCAN_EV) && (mode_q == MODE_TICK) && fire && out_free;
	assign load_fin  = (state_q == S_FIN) && out_free;

	// The adder serves the new expiry on insertion and the reload during a tick.
	always_comb begin
		if (state_q == S_DECIDE) begin
			add_a = req_q.now_time;
			add_b = {1'b0, req_q.period} + INCR_W'(delta_q);
		end else begin
			add_a = ent.slot_expiry;
			add_b = {1'b0, ent.slot_period};
		end
	end

	ktt_sat_add u_sat_add (
		.a   (add_a),
		.b   (add_b),
		.sum (add_sum)
	);

	// Memory ports.
	always_comb begin
		we    = 1'b0;
		waddr = wr_idx_q[IW-1:0];
		wdata = ent;
		re    = ((state_q == S_CNT_RD) || (state_q == S_SCAN_RD)) && !scan_end;
		if (state_q == S_DECIDE) begin
			waddr               = count_q[IW-1:0];
			wdata.slot_type     = req_q.timer_type;
			wdata.slot_subtype  = req_q.timer_subtype;
			wdata.slot_key      = req_q.timer_key;
			wdata.slot_expiry   = add_sum;
			wdata.slot_period   = req_q.period;
			wdata.slot_periodic = req_q.periodic;
			wdata.slot_tag      = req_q.tag_in;
			we = (mode_q == MODE_ADD) && !add_bad && (count_q != SLOTS_C);
		end else if (state_q == S_SCAN_EV) begin
			if (mode_q == MODE_REMOVE) begin
				we = !rm_del;
			end else if (mode_q == MODE_TICK) begin
				we = !tick_hold && (!fire || ent.slot_periodic);
				if (fire) begin
					wdata.slot_expiry = add_sum;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[rd_idx_q[IW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_q <= beat;
		end
		if (load_fire) begin
			o_status_q <= ST_OK;
			o_fired_q  <= 1'b1;
			o_type_q   <= ent.slot_type;
			o_sub_q    <= ent.slot_subtype;
			o_key_q    <= ent.slot_key;
			o_tag_q    <= ent.slot_tag;
			o_live_q   <= fcnt_q;
			o_last_q   <= ((emit_q + ONE_C) == nfire_q);
		end else if (load_fin) begin
			o_status_q <= status_q;
			o_fired_q  <= 1'b0;
			o_type_q   <= '0;
			o_sub_q    <= '0;
			o_key_q    <= '0;
			o_tag_q    <= tag_q;
			o_live_q   <= count_q;
			o_last_q   <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			mode_q     <= MODE_ADD;
			delta_q    <= '0;
			count_q    <= '0;
			rd_idx_q   <= '0;
			wr_idx_q   <= '0;
			found_q    <= 1'b0;
			nfire_q    <= '0;
			ndel_q     <= '0;
			emit_q     <= '0;
			fcnt_q     <= '0;
			status_q   <= ST_OK;
			tag_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				delta_q <= cfg_data;
			end

			if (load_fire || load_fin) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						mode_q  <= s_tuser;
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					rd_idx_q <= '0;
					wr_idx_q <= '0;
					found_q  <= 1'b0;
					nfire_q  <= '0;
					ndel_q   <= '0;
					emit_q   <= '0;
					tag_q    <= '0;
					status_q <= ST_OK;
					case (mode_q)
						MODE_ADD: begin
							state_q <= S_FIN;
							if (add_bad) begin
								status_q <= ST_INVALID;
							end else if (count_q == SLOTS_C) begin
								status_q <= ST_FULL;
							end else begin
								count_q <= count_q + ONE_C;
							end
						end
						MODE_TICK: begin
							state_q <= S_CNT_RD;
						end
						default: begin
							// Remove and lookup both refuse a zero type.
							if (req_q.timer_type == '0) begin
								status_q <= (mode_q == MODE_REMOVE) ? ST_INVALID : ST_NOTFOUND;
								state_q  <= S_FIN;
							end else begin
								state_q <= S_SCAN_RD;
							end
						end
					endcase
				end
				S_CNT_RD: begin
					if (scan_end) begin
						fcnt_q   <= count_q - ndel_q;
						rd_idx_q <= '0;
						state_q  <= S_SCAN_RD;
					end else begin
						state_q <= S_CNT_EV;
					end
				end
				S_CNT_EV: begin
					if (fire) begin
						nfire_q <= nfire_q + ONE_C;
						if (!ent.slot_periodic) begin
							ndel_q <= ndel_q + ONE_C;
						end
					end
					rd_idx_q <= rd_idx_q + ONE_C;
					state_q  <= S_CNT_RD;
				end
				S_SCAN_RD: begin
					if (scan_end) begin
						case (mode_q)
							MODE_LOOKUP: begin
								status_q <= ST_NOTFOUND;
								state_q  <= S_FIN;
							end
							MODE_REMOVE: begin
								count_q  <= wr_idx_q;
								status_q <= (req_q.any_subtype || found_q) ? ST_OK : ST_NOTFOUND;
								state_q  <= S_FIN;
							end
							default: begin
								count_q <= wr_idx_q;
								// A tick with nothing fired still gives one empty result.
								state_q <= (nfire_q == '0) ? S_FIN : S_IDLE;
							end
						endcase
					end else begin
						state_q <= S_SCAN_EV;
					end
				end
				S_SCAN_EV: begin
					case (mode_q)
						MODE_LOOKUP: begin
							if (exact_eq) begin
								tag_q   <= ent.slot_tag;
								state_q <= S_FIN;
							end else begin
								rd_idx_q <= rd_idx_q + ONE_C;
								state_q  <= S_SCAN_RD;
							end
						end
						MODE_REMOVE: begin
							if (rm_del) begin
								found_q <= 1'b1;
							end else begin
								wr_idx_q <= wr_idx_q + ONE_C;
							end
							rd_idx_q <= rd_idx_q + ONE_C;
							state_q  <= S_SCAN_RD;
						end
						default: begin
							if (!tick_hold) begin
								if (fire) begin
									emit_q <= emit_q + ONE_C;
								end
								if (!fire || ent.slot_periodic) begin
									wr_idx_q <= wr_idx_q + ONE_C;
								end
								rd_idx_q <= rd_idx_q + ONE_C;
								state_q  <= S_SCAN_RD;
							end
						end
					endcase
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = o_last_q;
	assign m_tdata  = OUT_DATA_W'({o_live_q, o_tag_q, o_key_q, o_sub_q, o_type_q,
		o_fired_q, o_status_q});

endmodule
